// ----- design/abstract_heap_transformer_assert.svh -----
// Assertion macros for the abstract heap transformer RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ABSTRACT_HEAP_TRANSFORMER_ASSERT_SVH
`define ABSTRACT_HEAP_TRANSFORMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define AHX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

// ----- design/ahx_pkg.sv -----
// Package for the abstract heap transformer: field widths, codes and defaults.
// No dependencies; the interfaces, distance unit, top level and testbench use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ahx_pkg;

    localparam int POINTER_COUNT_DEF = 8;
    localparam int NODE_COUNT_DEF    = 16;
    localparam int LIVE_LIMIT_DEF    = 4;
    localparam int DIST_WIDTH_DEF    = 32;

    localparam int MODE_W   = 3;
    localparam int PFIELD_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ASSIGN   = 3'd0,
        MODE_NEW      = 3'd1,
        MODE_LOOKUP   = 3'd2,
        MODE_UPDATE   = 3'd3,
        MODE_PATH     = 3'd4,
        MODE_ALIAS    = 3'd5,
        MODE_NULLTEST = 3'd6,
        MODE_VALIDATE = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NULL_UPD = 2'd2
    } status_t;

    typedef enum logic {
        DOP_ADD = 1'b0,
        DOP_DEC = 1'b1
    } dist_op_t;

endpackage
`default_nettype wire

// ----- design/ahx_if.sv -----
// Request and response channel interfaces of the abstract heap transformer.
// Depends on ahx_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ahx_req_if;
    logic                          valid;
    logic                          ready;
    logic [ahx_pkg::MODE_W-1:0]    mode;
    logic [ahx_pkg::PFIELD_W-1:0]  dest_ptr;
    logic [ahx_pkg::PFIELD_W-1:0]  src_ptr;

    modport source (output valid, mode, dest_ptr, src_ptr, input ready);
    modport sink   (input valid, mode, dest_ptr, src_ptr, output ready);
endinterface

interface ahx_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ahx_pkg::VALUE_W-1:0]   value;
    logic [ahx_pkg::STATUS_W-1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ----- design/ahx_store.sv -----
// Heap state storage: pointer table, successor and distance tables.
// One read port and one write port per table; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module ahx_store #(
    parameter int POINTER_COUNT = 8,
    parameter int NODE_COUNT    = 16,
    parameter int DIST_WIDTH    = 32,
    localparam int PW = $clog2(POINTER_COUNT),
    localparam int NW = $clog2(NODE_COUNT)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [PW-1:0]         ptr_ridx,
    output logic      [NW-1:0]         ptr_rdata,
    input  wire logic                  ptr_we,
    input  wire logic [PW-1:0]         ptr_widx,
    input  wire logic [NW-1:0]         ptr_wdata,
    input  wire logic [NW-1:0]         node_ridx,
    output logic      [NW-1:0]         succ_rdata,
    output logic      [DIST_WIDTH-1:0] dist_rdata,
    input  wire logic                  node_we,
    input  wire logic [NW-1:0]         node_widx,
    input  wire logic [NW-1:0]         succ_wdata,
    input  wire logic [DIST_WIDTH-1:0] dist_wdata
);

    logic [NW-1:0]         ptr_reg  [POINTER_COUNT];
    logic [NW-1:0]         succ_reg [NODE_COUNT];
    logic [DIST_WIDTH-1:0] dist_reg [NODE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POINTER_COUNT; i++)
            begin
                ptr_reg[i] <= '0;
            end
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                succ_reg[i] <= '0;
                dist_reg[i] <= '0;
            end
        end
        else
        begin
            if (ptr_we)
            begin
                ptr_reg[ptr_widx] <= ptr_wdata;
            end
            if (node_we)
            begin
                succ_reg[node_widx] <= succ_wdata;
                dist_reg[node_widx] <= dist_wdata;
            end
        end
    end

    assign ptr_rdata  = ptr_reg[ptr_ridx];
    assign succ_rdata = succ_reg[node_ridx];
    assign dist_rdata = dist_reg[node_ridx];

endmodule
`default_nettype wire

// ----- design/ahx_dist_unit.sv -----
// Shared saturating distance unit: saturating add, or decrement that holds
// infinity and stops at zero. Depends on ahx_pkg for the operation code.
`timescale 1ns / 1ps
`default_nettype none
module ahx_dist_unit #(
    parameter int DIST_WIDTH = 32
) (
    input  wire logic [DIST_WIDTH-1:0] a,
    input  wire logic [DIST_WIDTH-1:0] b,
    input  wire ahx_pkg::dist_op_t     op,
    output logic      [DIST_WIDTH-1:0] y
);

    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

    logic [DIST_WIDTH:0] sum;

    always_comb
    begin
        sum = {1'b0, a} + {1'b0, b};
        case (op)
            ahx_pkg::DOP_ADD:
            begin
                y = sum[DIST_WIDTH] ? DIST_INF : sum[DIST_WIDTH-1:0];
            end
            ahx_pkg::DOP_DEC:
            begin
                if (a == DIST_INF || a == '0)
                begin
                    y = a;
                end
                else
                begin
                    y = a - DIST_WIDTH'(1);
                end
            end
            default:
            begin
                y = a;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/abstract_heap_transformer.sv -----
// Abstract heap transformer top level: request sequencer and result register.
// Depends on ahx_pkg, ahx_if, ahx_store, ahx_dist_unit and the assert header.
//
// Usage: requests arrive on the req channel (mode, dest_ptr, src_ptr) and each
// request yields exactly one response (value, status) on the rsp channel. A
// request is taken when valid and ready are both high. The block works on one
// request at a time: req.ready is high only while the sequencer is idle.
// After acceptance, assign, new, update, alias and null test pass through the
// pointer reads (S_RDX, S_RDY) and S_EXEC to S_DONE, where the response is
// loaded; lookup adds a node read (S_RDN) before S_EXEC, and a lookup that
// splits a long edge adds S_LINK, which relinks the old edge. Path length
// walks one node per cycle in S_WALK through the single table read port and
// the shared saturating adder, and validate walks every pointer's chain one
// node per cycle.
// Reset clears every pointer and edge to the null node and sets the node
// count to one. The response sits in an output register; while the receiver
// stalls, the block may still finish the next request's work but holds it
// until the output register frees up, and accepts nothing new meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "abstract_heap_transformer_assert.svh"
module abstract_heap_transformer #(
    parameter int POINTER_COUNT = ahx_pkg::POINTER_COUNT_DEF,
    parameter int NODE_COUNT    = ahx_pkg::NODE_COUNT_DEF,
    parameter int LIVE_LIMIT    = ahx_pkg::LIVE_LIMIT_DEF,
    parameter int DIST_WIDTH    = ahx_pkg::DIST_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    ahx_req_if.sink  req,
    ahx_rsp_if.source rsp
);

    localparam int PW  = $clog2(POINTER_COUNT);
    localparam int PCW = $clog2(POINTER_COUNT + 1);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int CW  = $clog2(NODE_COUNT + 1);
    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;
    localparam logic [DIST_WIDTH-1:0] DIST_ONE = DIST_WIDTH'(1);

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RDX   = 12'b000000000010,
        S_RDY   = 12'b000000000100,
        S_RDN   = 12'b000000001000,
        S_EXEC  = 12'b000000010000,
        S_LINK  = 12'b000000100000,
        S_WALK  = 12'b000001000000,
        S_VINIT = 12'b000010000000,
        S_VPTR  = 12'b000100000000,
        S_VSTEP = 12'b001000000000,
        S_VFIN  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    ahx_pkg::mode_t mode_reg, mode_next;
    logic [ahx_pkg::PFIELD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [NW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [NW-1:0]  yn_reg, yn_next, n_reg, n_next, last_reg, last_next;
    logic [DIST_WIDTH-1:0] d_reg, d_next, acc_reg, acc_next;
    logic [CW-1:0]  nc_reg, nc_next, cnt_reg, cnt_next, nreach_reg, nreach_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [NODE_COUNT-1:0] named_reg, named_next, reach_reg, reach_next;
    logic [NODE_COUNT-1:0] deg1_reg, deg1_next, deg2_reg, deg2_next;
    logic [ahx_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    ahx_pkg::status_t res_status_reg, res_status_next;
    logic [ahx_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    ahx_pkg::status_t out_status_reg, out_status_next;
    logic out_valid_reg, out_valid_next;

    // Storage ports.
    logic [PW-1:0]         ptr_ridx, ptr_widx;
    logic [NW-1:0]         ptr_rdata, ptr_wdata;
    logic                  ptr_we;
    logic [NW-1:0]         node_ridx, node_widx, succ_rdata, succ_wdata;
    logic [DIST_WIDTH-1:0] dist_rdata, dist_wdata;
    logic                  node_we;

    // Shared distance unit.
    logic [DIST_WIDTH-1:0] du_a, du_y;
    ahx_pkg::dist_op_t     du_op;

    logic x_ok, y_ok, full, chain_bad, heap_ok;

    ahx_store #(
        .POINTER_COUNT (POINTER_COUNT),
        .NODE_COUNT    (NODE_COUNT),
        .DIST_WIDTH    (DIST_WIDTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ptr_ridx   (ptr_ridx),
        .ptr_rdata  (ptr_rdata),
        .ptr_we     (ptr_we),
        .ptr_widx   (ptr_widx),
        .ptr_wdata  (ptr_wdata),
        .node_ridx  (node_ridx),
        .succ_rdata (succ_rdata),
        .dist_rdata (dist_rdata),
        .node_we    (node_we),
        .node_widx  (node_widx),
        .succ_wdata (succ_wdata),
        .dist_wdata (dist_wdata)
    );

    // The walk accumulates with saturating adds; a lookup split decrements.
    assign du_a  = (state_reg == S_WALK) ? acc_reg : d_reg;
    assign du_op = (state_reg == S_WALK) ? ahx_pkg::DOP_ADD : ahx_pkg::DOP_DEC;

    ahx_dist_unit #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dist (
        .a  (du_a),
        .b  (dist_rdata),
        .op (du_op),
        .y  (du_y)
    );

    // Pointer indices at or above the table size read as null and drop writes.
    assign x_ok = int'(x_reg) < POINTER_COUNT;
    assign y_ok = int'(y_reg) < POINTER_COUNT;
    assign full = nc_reg >= CW'(NODE_COUNT);

    // A reachable node that no pointer names must be a join point.
    assign chain_bad = |(~named_reg & reach_reg & ~deg2_reg);
    assign heap_ok   = !chain_bad && (nc_reg == nreach_reg)
                       && (int'(nreach_reg) <= 2 * LIVE_LIMIT + 1);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        yn_next         = yn_reg;
        d_next          = d_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        nc_next         = nc_reg;
        cnt_next        = cnt_reg;
        nreach_next     = nreach_reg;
        p_next          = p_reg;
        named_next      = named_reg;
        reach_next      = reach_reg;
        deg1_next       = deg1_reg;
        deg2_next       = deg2_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;

        ptr_ridx   = PW'(y_reg);
        node_ridx  = py_reg;
        ptr_we     = 1'b0;
        ptr_widx   = PW'(x_reg);
        ptr_wdata  = py_reg;
        node_we    = 1'b0;
        node_widx  = px_reg;
        succ_wdata = py_reg;
        dist_wdata = DIST_ONE;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = ahx_pkg::mode_t'(req.mode);
                    x_next          = req.dest_ptr;
                    y_next          = req.src_ptr;
                    res_value_next  = '0;
                    res_status_next = ahx_pkg::STAT_OK;
                    if (ahx_pkg::mode_t'(req.mode) == ahx_pkg::MODE_VALIDATE)
                    begin
                        state_next = S_VINIT;
                    end
                    else
                    begin
                        state_next = S_RDX;
                    end
                end
            end
            S_RDX:
            begin
                ptr_ridx   = PW'(x_reg);
                px_next    = x_ok ? ptr_rdata : '0;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                ptr_ridx = PW'(y_reg);
                py_next  = y_ok ? ptr_rdata : '0;
                if (mode_reg == ahx_pkg::MODE_LOOKUP)
                begin
                    state_next = S_RDN;
                end
                else if (mode_reg == ahx_pkg::MODE_PATH)
                begin
                    n_next     = px_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_RDN:
            begin
                node_ridx  = py_reg;
                yn_next    = succ_rdata;
                d_next     = dist_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    ahx_pkg::MODE_ASSIGN:
                    begin
                        ptr_we    = x_ok;
                        ptr_wdata = py_reg;
                    end
                    ahx_pkg::MODE_NEW:
                    begin
                        if (full)
                        begin
                            res_status_next = ahx_pkg::STAT_FULL;
                        end
                        else
                        begin
                            node_we    = 1'b1;
                            node_widx  = NW'(nc_reg);
                            succ_wdata = '0;
                            dist_wdata = DIST_ONE;
                            ptr_we     = x_ok;
                            ptr_wdata  = NW'(nc_reg);
                            nc_next    = nc_reg + CW'(1);
                        end
                    end
                    ahx_pkg::MODE_LOOKUP:
                    begin
                        if (d_reg == DIST_ONE)
                        begin
                            ptr_we    = x_ok;
                            ptr_wdata = yn_reg;
                        end
                        else if (full)
                        begin
                            res_status_next = ahx_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // Split the long edge: the new node takes the rest.
                            node_we    = 1'b1;
                            node_widx  = NW'(nc_reg);
                            succ_wdata = yn_reg;
                            dist_wdata = du_y;
                            ptr_we     = x_ok;
                            ptr_wdata  = NW'(nc_reg);
                            n_next     = NW'(nc_reg);
                            nc_next    = nc_reg + CW'(1);
                            state_next = S_LINK;
                        end
                    end
                    ahx_pkg::MODE_UPDATE:
                    begin
                        if (px_reg == '0)
                        begin
                            res_status_next = ahx_pkg::STAT_NULL_UPD;
                        end
                        else
                        begin
                            node_we    = 1'b1;
                            node_widx  = px_reg;
                            succ_wdata = py_reg;
                            dist_wdata = DIST_ONE;
                        end
                    end
                    ahx_pkg::MODE_ALIAS:
                    begin
                        res_value_next = ahx_pkg::VALUE_W'(px_reg == py_reg);
                    end
                    ahx_pkg::MODE_NULLTEST:
                    begin
                        res_value_next = ahx_pkg::VALUE_W'(px_reg == '0);
                    end
                    default:
                    begin
                        res_value_next = '0;
                    end
                endcase
            end
            S_LINK:
            begin
                node_we    = 1'b1;
                node_widx  = py_reg;
                succ_wdata = n_reg;
                dist_wdata = DIST_ONE;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                node_ridx = n_reg;
                if (n_reg == py_reg)
                begin
                    res_value_next = ahx_pkg::VALUE_W'(acc_reg);
                    state_next     = S_DONE;
                end
                else if (cnt_reg == CW'(NODE_COUNT))
                begin
                    res_value_next = ahx_pkg::VALUE_W'(DIST_INF);
                    state_next     = S_DONE;
                end
                else
                begin
                    acc_next = du_y;
                    n_next   = succ_rdata;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_VINIT:
            begin
                ptr_ridx  = '0;
                node_ridx = '0;
                if (ptr_rdata != '0 || succ_rdata != '0 || dist_rdata != '0)
                begin
                    res_value_next = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    named_next  = '0;
                    reach_next  = '0;
                    deg1_next   = '0;
                    deg2_next   = '0;
                    p_next      = '0;
                    last_next   = '0;
                    nreach_next = '0;
                    state_next  = S_VPTR;
                end
            end
            S_VPTR:
            begin
                ptr_ridx          = p_reg[PW-1:0];
                n_next            = ptr_rdata;
                named_next[ptr_rdata] = 1'b1;
                cnt_next          = '0;
                state_next        = S_VSTEP;
            end
            S_VSTEP:
            begin
                node_ridx = n_reg;
                if (reach_reg[n_reg] || cnt_reg == CW'(NODE_COUNT - 1))
                begin
                    p_next = p_reg + PCW'(1);
                    if (p_reg == PCW'(POINTER_COUNT - 1))
                    begin
                        state_next = S_VFIN;
                    end
                    else
                    begin
                        state_next = S_VPTR;
                    end
                end
                else if (CW'(n_reg) >= nc_reg || dist_rdata == DIST_INF
                         || (n_reg != '0 && dist_rdata == '0) || n_reg < last_reg)
                begin
                    res_value_next = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    last_next              = n_reg;
                    reach_next[n_reg]      = 1'b1;
                    nreach_next            = nreach_reg + CW'(1);
                    n_next                 = succ_rdata;
                    deg1_next[succ_rdata]  = 1'b1;
                    deg2_next[succ_rdata]  = deg1_reg[succ_rdata];
                    cnt_next               = cnt_reg + CW'(1);
                end
            end
            S_VFIN:
            begin
                res_value_next = ahx_pkg::VALUE_W'(heap_ok);
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nc_reg        <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nc_reg        <= nc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        yn_reg         <= yn_next;
        d_reg          <= d_next;
        n_reg          <= n_next;
        last_reg       <= last_next;
        acc_reg        <= acc_next;
        cnt_reg        <= cnt_next;
        nreach_reg     <= nreach_next;
        p_reg          <= p_next;
        named_reg      <= named_next;
        reach_reg      <= reach_next;
        deg1_reg       <= deg1_next;
        deg2_reg       <= deg2_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // The node count always covers the null node and never exceeds the store.
    `AHX_ASSERT_NOW(a_nc_bounds, 1'b1, nc_reg >= CW'(1) && nc_reg <= CW'(NODE_COUNT))
    // Nodes are only ever allocated one at a time.
    `AHX_ASSERT_NEXT(a_nc_step, 1'b1, nc_reg == $past(nc_reg) || nc_reg == $past(nc_reg) + CW'(1))
    // In the cycle after a request is taken the block is busy.
    `AHX_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)

endmodule
`default_nettype wire

// ----- test/abstract_heap_transformer_tb.sv -----
// Self-checking testbench for the abstract heap transformer.
// Depends on ahx_pkg, ahx_if and the abstract_heap_transformer RTL.
`timescale 1ns / 1ps
module abstract_heap_transformer_tb;

    localparam int NPTR = ahx_pkg::POINTER_COUNT_DEF;
    localparam int NNODE = ahx_pkg::NODE_COUNT_DEF;
    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [ahx_pkg::VALUE_W-1:0] value;
        ahx_pkg::status_t            status;
    } heap_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ahx_req_if req ();
    ahx_rsp_if rsp ();

    abstract_heap_transformer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // Shadow copy of the abstract heap, updated as each request is accepted.
    logic [3:0]  shadow_ptr [NPTR];
    logic [3:0]  shadow_succ [NNODE];
    logic [31:0] shadow_dist [NNODE];
    int          shadow_nodes;

    heap_result_t expected_results [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit stall_heavy = 1'b0;

    function automatic logic [31:0] dist_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? DIST_INF : s[31:0];
    endfunction

    // Walk from the node pointer x names until the node pointer y names is met; infinite if it never is.
    function automatic logic [31:0] walk_length(logic [2:0] x, logic [2:0] y);
        logic [31:0] acc;
        logic [3:0]  n;
        logic [3:0]  target;
        acc = '0;
        n = shadow_ptr[x];
        target = shadow_ptr[y];
        for (int i = 0; i < NNODE + 1; i++)
        begin
            if (n == target)
                return acc;
            acc = dist_sum(acc, shadow_dist[n]);
            n = shadow_succ[n];
        end
        return DIST_INF;
    endfunction

    // Well-formedness: clean null node, chains in ascending node order, no dangling or
    // unnamed nodes that are passed through only once, exact node count within the live limit.
    function automatic bit heap_well_formed();
        bit          named [NNODE];
        bit          reach [NNODE];
        int          indeg [NNODE];
        int          nreach;
        int          last;
        logic [3:0]  n;
        nreach = 0;
        last = 0;
        if (shadow_ptr[0] != 0 || shadow_succ[0] != 0 || shadow_dist[0] != 0)
            return 1'b0;
        for (int k = 0; k < NNODE; k++)
        begin
            named[k] = 1'b0;
            reach[k] = 1'b0;
            indeg[k] = 0;
        end
        for (int p = 0; p < NPTR; p++)
        begin
            n = shadow_ptr[p];
            named[n] = 1'b1;
            for (int i = 0; i + 1 < NNODE; i++)
            begin
                if (!reach[n])
                begin
                    if (n >= shadow_nodes || shadow_dist[n] == DIST_INF)
                        return 1'b0;
                    if (n != 0 && shadow_dist[n] == 0)
                        return 1'b0;
                    if (n < last)
                        return 1'b0;
                    last = n;
                    reach[n] = 1'b1;
                    nreach++;
                    n = shadow_succ[n];
                    indeg[n]++;
                end
            end
        end
        for (int k = 0; k < NNODE; k++)
            if (!named[k] && reach[k] && indeg[k] <= 1)
                return 1'b0;
        if (shadow_nodes != nreach)
            return 1'b0;
        return nreach <= ahx_pkg::LIVE_LIMIT_DEF * 2 + 1;
    endfunction

    // Applies one request to the shadow heap and returns its response.
    function automatic heap_result_t heap_apply(ahx_pkg::mode_t m, logic [2:0] x,
                                                logic [2:0] y);
        heap_result_t r;
        logic [3:0]  py;
        logic [3:0]  yn;
        logic [31:0] d;
        logic [3:0]  fresh;
        r.value = '0;
        r.status = ahx_pkg::STAT_OK;
        case (m)
            ahx_pkg::MODE_ASSIGN: shadow_ptr[x] = shadow_ptr[y];
            ahx_pkg::MODE_NEW:
            begin
                if (shadow_nodes >= NNODE)
                begin
                    r.status = ahx_pkg::STAT_FULL;
                end
                else
                begin
                    fresh = shadow_nodes[3:0];
                    shadow_nodes++;
                    shadow_succ[fresh] = '0;
                    shadow_dist[fresh] = 32'd1;
                    shadow_ptr[x] = fresh;
                end
            end
            ahx_pkg::MODE_LOOKUP:
            begin
                py = shadow_ptr[y];
                yn = shadow_succ[py];
                d = shadow_dist[py];
                if (d == 32'd1)
                begin
                    shadow_ptr[x] = yn;
                end
                else if (shadow_nodes >= NNODE)
                begin
                    r.status = ahx_pkg::STAT_FULL;
                end
                else
                begin
                    // Split the long edge: py -> fresh (1) -> yn (d - 1).
                    fresh = shadow_nodes[3:0];
                    shadow_nodes++;
                    shadow_succ[fresh] = yn;
                    shadow_dist[fresh] = (d == DIST_INF) ? DIST_INF :
                                         (d == 0) ? 32'd0 : d - 32'd1;
                    shadow_succ[py] = fresh;
                    shadow_dist[py] = 32'd1;
                    shadow_ptr[x] = fresh;
                end
            end
            ahx_pkg::MODE_UPDATE:
            begin
                if (shadow_ptr[x] == 0)
                begin
                    r.status = ahx_pkg::STAT_NULL_UPD;
                end
                else
                begin
                    shadow_succ[shadow_ptr[x]] = shadow_ptr[y];
                    shadow_dist[shadow_ptr[x]] = 32'd1;
                end
            end
            ahx_pkg::MODE_PATH:     r.value = walk_length(x, y);
            ahx_pkg::MODE_ALIAS:    r.value = (shadow_ptr[x] == shadow_ptr[y]) ? 32'd1 : 32'd0;
            ahx_pkg::MODE_NULLTEST: r.value = (shadow_ptr[x] == 0) ? 32'd1 : 32'd0;
            default:                r.value = heap_well_formed() ? 32'd1 : 32'd0;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request; valid stays high across back-to-back requests.
    task automatic send_request(ahx_pkg::mode_t m, logic [2:0] x, logic [2:0] y, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid <= 1'b1;
        req.mode <= m;
        req.dest_ptr <= x;
        req.src_ptr <= y;
        do @(posedge clk); while (!req.ready);
        expected_results.push_back(heap_apply(m, x, y));
    endtask

    task automatic send_random(ahx_pkg::mode_t m);
        send_request(m, 3'($urandom), 3'($urandom), pick_gap());
    endtask

    // Empty heap: every test on the null node, then an update through null and an assignment.
    task automatic test_empty_heap();
        send_request(ahx_pkg::MODE_VALIDATE, 3'd0, 3'd0, 0);
        send_request(ahx_pkg::MODE_NULLTEST, 3'd7, 3'd0, 0);
        send_request(ahx_pkg::MODE_ALIAS, 3'd0, 3'd7, 1);
        send_request(ahx_pkg::MODE_PATH, 3'd3, 3'd5, 0);
        send_request(ahx_pkg::MODE_UPDATE, 3'd2, 3'd4, 0);
        send_request(ahx_pkg::MODE_ASSIGN, 3'd6, 3'd1, 2);
    endtask

    // Builds a short list, splits an edge, walks it and checks each mode.
    task automatic test_each_mode();
        send_request(ahx_pkg::MODE_NEW, 3'd1, 3'd0, 0);
        send_request(ahx_pkg::MODE_NEW, 3'd2, 3'd0, 0);
        send_request(ahx_pkg::MODE_UPDATE, 3'd1, 3'd2, 0);
        send_request(ahx_pkg::MODE_VALIDATE, 3'd0, 3'd0, 0);
        send_request(ahx_pkg::MODE_PATH, 3'd1, 3'd2, 0);
        send_request(ahx_pkg::MODE_PATH, 3'd2, 3'd1, 0);
        send_request(ahx_pkg::MODE_LOOKUP, 3'd3, 3'd1, 0);
        send_request(ahx_pkg::MODE_ALIAS, 3'd3, 3'd2, 0);
        send_request(ahx_pkg::MODE_ASSIGN, 3'd7, 3'd2, 0);
        send_request(ahx_pkg::MODE_ALIAS, 3'd7, 3'd2, 0);
        send_request(ahx_pkg::MODE_NULLTEST, 3'd7, 3'd0, 0);
        // Lookup through null splits the zero-length null edge.
        send_request(ahx_pkg::MODE_LOOKUP, 3'd4, 3'd0, 0);
        send_request(ahx_pkg::MODE_VALIDATE, 3'd0, 3'd0, 0);
        send_request(ahx_pkg::MODE_UPDATE, 3'd2, 3'd2, 0);
        send_request(ahx_pkg::MODE_PATH, 3'd2, 3'd5, 0);
    endtask

    // Mixes allocations with every other mode for count random requests.
    task automatic test_random_heap(int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (i % 200 == 0)
                stall_heavy = $urandom_range(0, 1);
            if (roll < 12)
                send_random(ahx_pkg::MODE_NEW);
            else if (roll < 26)
                send_random(ahx_pkg::MODE_LOOKUP);
            else if (roll < 40)
                send_random(ahx_pkg::MODE_UPDATE);
            else if (roll < 52)
                send_random(ahx_pkg::MODE_ASSIGN);
            else if (roll < 68)
                send_random(ahx_pkg::MODE_PATH);
            else if (roll < 78)
                send_random(ahx_pkg::MODE_ALIAS);
            else if (roll < 86)
                send_random(ahx_pkg::MODE_NULLTEST);
            else
                send_random(ahx_pkg::MODE_VALIDATE);
        end
    endtask

    // Receiver stalls: short ones mostly, long ones now and then.
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < (stall_heavy ? 30 : 8))
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 3);
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    // Compares each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response value=%h status=%0d",
                             rsp.value, rsp.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.value !== want.value || rsp.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                 want.value, want.status, rsp.value, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int drain;
        req.valid = 1'b0;
        req.mode = ahx_pkg::MODE_ASSIGN;
        req.dest_ptr = '0;
        req.src_ptr = '0;
        rsp.ready = 1'b0;
        for (int k = 0; k < NPTR; k++)
            shadow_ptr[k] = '0;
        for (int k = 0; k < NNODE; k++)
        begin
            shadow_succ[k] = '0;
            shadow_dist[k] = '0;
        end
        shadow_nodes = 1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_heap();
        test_each_mode();
        test_random_heap(1700);

        @(negedge clk);
        req.valid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (NPTR * (NNODE + 1) + 20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/ahx_pkg.sv
design/ahx_if.sv
design/ahx_store.sv
design/ahx_dist_unit.sv
design/abstract_heap_transformer.sv
test/abstract_heap_transformer_tb.sv
